FILE: src/htw_pkg.sv
`default_nettype none
package htw_pkg;
   localparam int NearBitsDef  = 8;
   localparam int LevelBitsDef = 6;
   localparam int PoolDepthDef = 64;
   localparam int Levels       = 4;
   localparam int MaxResults   = 64;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_FLUSH  = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_FREE,
      ST_FILE,
      ST_FILE_WR,
      ST_CAS_HEAD,
      ST_CAS_NODE,
      ST_EXP_HEAD,
      ST_EXP_NODE,
      ST_EXP_OUT,
      ST_REJECT,
      ST_CLEAR
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_LATCH,
      CMD_INS_FREE,
      CMD_FILE_RD,
      CMD_FILE_WR,
      CMD_ADVANCE,
      CMD_CAS_HEAD,
      CMD_CAS_NEXT,
      CMD_EXP_HEAD,
      CMD_EXP_POP
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
   } ctrl_type;

   typedef struct packed {
      logic clear_done;
      logic pool_empty;
      logic cas_needed;
      logic cur_valid;
      logic exp_more;
   } stat_type;
endpackage
`default_nettype wire

FILE: src/htw_if.sv
`default_nettype none
interface htw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [63:0] handle;
   logic signed [31:0] delay;
   modport source (output valid, operation, handle, delay, input ready);
   modport sink   (input valid, operation, handle, delay, output ready);
endinterface

interface htw_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] expired_id;
   logic        status;
   logic        last;
   modport source (output valid, expired_id, status, last, input ready);
   modport sink   (input valid, expired_id, status, last, output ready);
endinterface
`default_nettype wire

FILE: src/hierarchical_timer_wheel_top.sv
`default_nettype none
// channel | dir | payload
// req     | in  | operation, handle, delay
// rsp     | out | expired_id, status, last
// Insert: takes a free node and files it into its bucket; a full pool rejects it.
// Flush: walks the current near slot and returns each expired id.
// Tick: advances the clock, cascades a coarse bucket at a boundary, then flushes.
// After reset a clearing pass sweeps the bucket table; no transfer is
// accepted meanwhile. Results sit in an output register; the expiry walk
// and the input stall while it is full.
module hierarchical_timer_wheel_top
   import htw_pkg::*;
#(
   parameter int NEAR_BITS  = NearBitsDef,
   parameter int LEVEL_BITS = LevelBitsDef,
   parameter int POOL_DEPTH = PoolDepthDef
) (
   input wire logic clock,
   input wire logic reset,
   htw_req_if.sink   req,
   htw_rsp_if.source rsp
);
   ctrl_type ctrl;
   stat_type stat;
   logic push, st, lst;
   logic [63:0] ident;
   logic v_ff;
   logic [63:0] id_ff;
   logic st_ff, last_ff;

   htw_ctrl u_ctrl (
      .clock, .reset, .req_valid(req.valid), .req_op(req.operation),
      .req_ready(req.ready), .out_busy(v_ff && !rsp.ready), .out_push(push),
      .out_status(st), .out_last(lst), .ctrl, .stat
   );

   htw_datapath #(.NEAR_BITS(NEAR_BITS), .LEVEL_BITS(LEVEL_BITS),
      .POOL_DEPTH(POOL_DEPTH)) u_dp (
      .clock, .reset, .req_handle(req.handle), .req_delay(req.delay),
      .ctrl, .stat, .id_out(ident)
   );

   // rejected inserts echo the latched id through the same register
   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (push) v_ff <= 1'b1;
      else if (rsp.ready) v_ff <= 1'b0;
      if (push) begin
         id_ff   <= ident;
         st_ff   <= st;
         last_ff <= lst;
      end
   end
   assign rsp.valid      = v_ff;
   assign rsp.expired_id = id_ff;
   assign rsp.status     = st_ff;
   assign rsp.last       = last_ff;
endmodule
`default_nettype wire

FILE: src/htw_ctrl.sv
`default_nettype none
module htw_ctrl
   import htw_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire logic [1:0] req_op,
   output logic          req_ready,
   input  wire logic     out_busy,
   output logic          out_push,
   output logic          out_status,
   output logic          out_last,
   output ctrl_type      ctrl,
   input  wire stat_type stat
);
   state_type state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic [6:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         op_ff    <= OP_INSERT;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      cnt_in     = cnt_ff;
      req_ready  = 1'b0;
      out_push   = 1'b0;
      out_status = 1'b0;
      out_last   = 1'b0;
      ctrl.cmd   = CMD_NONE;
      case (state_ff)
         ST_CLEAR: begin
            ctrl.cmd = CMD_CLEAR;
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = !out_busy;
            if (req_valid && !out_busy) begin
               ctrl.cmd = CMD_LATCH;
               op_in    = req_op;
               cnt_in   = '0;
               case (req_op)
                  OP_INSERT: state_in = ST_INS_FREE;
                  OP_FLUSH:  state_in = ST_EXP_HEAD;
                  OP_TICK:   state_in = ST_CAS_HEAD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_INS_FREE: begin
            if (stat.pool_empty) state_in = ST_REJECT;
            else begin
               ctrl.cmd = CMD_INS_FREE;
               state_in = ST_FILE;
            end
         end
         ST_REJECT: begin
            out_push   = 1'b1;
            out_status = 1'b1;
            out_last   = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_FILE: begin
            ctrl.cmd = CMD_FILE_RD;
            state_in = ST_FILE_WR;
         end
         ST_FILE_WR: begin
            ctrl.cmd = CMD_FILE_WR;
            state_in = (op_ff == OP_INSERT) ? ST_IDLE : ST_CAS_NODE;
         end
         ST_CAS_HEAD: begin
            // advance clock; if a boundary was crossed, detach coarse bucket
            ctrl.cmd = stat.cas_needed ? CMD_CAS_HEAD : CMD_ADVANCE;
            state_in = stat.cas_needed ? ST_CAS_NODE : ST_EXP_HEAD;
         end
         ST_CAS_NODE: begin
            if (stat.cur_valid) begin
               ctrl.cmd = CMD_CAS_NEXT;
               state_in = ST_FILE;
            end else state_in = ST_EXP_HEAD;
         end
         ST_EXP_HEAD: begin
            ctrl.cmd = CMD_EXP_HEAD;
            state_in = ST_EXP_NODE;
         end
         ST_EXP_NODE: begin
            if (stat.exp_more && !out_busy) begin
               ctrl.cmd = CMD_EXP_POP;
               state_in = ST_EXP_OUT;
            end else if (!stat.exp_more) state_in = ST_IDLE;
         end
         ST_EXP_OUT: begin
            out_push = 1'b1;
            cnt_in   = cnt_ff + 7'd1;
            if (!stat.exp_more || cnt_ff == 7'(MaxResults - 1)) begin
               out_last = 1'b1;
               state_in = ST_IDLE;
            end else state_in = ST_EXP_NODE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

FILE: src/htw_datapath.sv
`default_nettype none
module htw_datapath
   import htw_pkg::*;
#(
   parameter int NEAR_BITS  = NearBitsDef,
   parameter int LEVEL_BITS = LevelBitsDef,
   parameter int POOL_DEPTH = PoolDepthDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [63:0] req_handle,
   input  wire logic [31:0] req_delay,
   input  wire ctrl_type    ctrl,
   output stat_type         stat,
   output logic [63:0]      id_out
);
   localparam int NearSlots  = 1 << NEAR_BITS;
   localparam int LevelSlots = 1 << LEVEL_BITS;
   localparam int Buckets    = NearSlots + Levels * LevelSlots;
   localparam int BW = $clog2(Buckets);
   localparam int PW = $clog2(POOL_DEPTH + 1);   // holds null link
   localparam int NW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int ClrLen = (Buckets > POOL_DEPTH) ? Buckets : POOL_DEPTH;
   localparam int CW = $clog2(ClrLen + 1);
   localparam logic [PW-1:0] Nil = PW'(POOL_DEPTH);

   logic [31:0]   node_expire [POOL_DEPTH];
   logic [63:0]   node_ident  [POOL_DEPTH];
   logic [PW-1:0] node_link   [POOL_DEPTH];
   logic [PW-1:0] bkt_head [Buckets];
   logic [PW-1:0] bkt_tail [Buckets];

   logic [31:0]   now_ff;
   logic [PW-1:0] free_ff;
   logic [PW-1:0] cur_ff, nxt_ff;
   logic [63:0]   id_ff, ident_ff;
   logic [31:0]   dly_ff, exp_ff;
   logic [BW-1:0] bkt_ff;
   logic [CW-1:0] clr_ff;
   logic          clr_done_ff;
   logic [PW-1:0] hd_ff, tl_ff;

   wire [31:0] now_inc = now_ff + 32'd1;
   logic          cas_need;
   logic [BW-1:0] cas_bkt;
   always_comb begin
      cas_need = 1'b0;
      cas_bkt  = '0;
      if (now_inc == 32'd0) begin
         cas_need = 1'b1;
         cas_bkt  = BW'(NearSlots + 3 * LevelSlots);
      end else begin
         for (int i = Levels - 1; i >= 0; i--) begin
            if ((now_inc & ((32'd1 << (NEAR_BITS + i * LEVEL_BITS)) - 32'd1)) == 32'd0 &&
                (((now_inc >> (NEAR_BITS + i * LEVEL_BITS)) & 32'(LevelSlots - 1)) != 0)) begin
               cas_need = 1'b1;
               cas_bkt  = BW'(NearSlots + i * LevelSlots) +
                  BW'((now_inc >> (NEAR_BITS + i * LEVEL_BITS)) & 32'(LevelSlots - 1));
            end
         end
      end
   end

   logic [BW-1:0] file_bkt;
   always_comb begin
      logic found;
      found    = 1'b0;
      file_bkt = BW'(NearSlots + 3 * LevelSlots) +
         BW'((exp_ff >> (NEAR_BITS + 3 * LEVEL_BITS)) & 32'(LevelSlots - 1));
      if ((exp_ff >> NEAR_BITS) == (now_ff >> NEAR_BITS)) begin
         found    = 1'b1;
         file_bkt = BW'(exp_ff & 32'(NearSlots - 1));
      end
      for (int i = 0; i < 3; i++) begin
         if (!found && ((exp_ff >> (NEAR_BITS + (i + 1) * LEVEL_BITS)) ==
                        (now_ff >> (NEAR_BITS + (i + 1) * LEVEL_BITS)))) begin
            found    = 1'b1;
            file_bkt = BW'(NearSlots + i * LevelSlots) +
               BW'((exp_ff >> (NEAR_BITS + i * LEVEL_BITS)) & 32'(LevelSlots - 1));
         end
      end
   end

   wire [BW-1:0] near_bkt = BW'(now_ff & 32'(NearSlots - 1));
   wire [NW-1:0] cur_i = cur_ff[NW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff      <= '0;
         free_ff     <= '0;
         clr_ff      <= '0;
         clr_done_ff <= 1'b0;
         cur_ff      <= Nil;
      end else begin
         case (ctrl.cmd)
            CMD_CLEAR: begin
               if (!clr_done_ff) begin
                  if (clr_ff < CW'(Buckets)) begin
                     bkt_head[clr_ff[BW-1:0]] <= Nil;
                     bkt_tail[clr_ff[BW-1:0]] <= Nil;
                  end
                  if (clr_ff < CW'(POOL_DEPTH))
                     node_link[clr_ff[NW-1:0]] <= PW'(clr_ff) + PW'(1);
                  clr_ff <= clr_ff + CW'(1);
                  if (clr_ff == CW'(ClrLen - 1)) clr_done_ff <= 1'b1;
               end
            end
            CMD_LATCH: begin
               id_ff    <= req_handle;
               ident_ff <= req_handle;
               dly_ff   <= req_delay[31] ? 32'd0 : req_delay;
            end
            CMD_INS_FREE: begin
               cur_ff              <= free_ff;
               free_ff             <= node_link[free_ff[NW-1:0]];
               node_ident[free_ff[NW-1:0]]  <= id_ff;
               node_expire[free_ff[NW-1:0]] <= now_ff + dly_ff;
               exp_ff              <= now_ff + dly_ff;
            end
            CMD_FILE_RD: begin
               bkt_ff <= file_bkt;
               hd_ff  <= bkt_head[file_bkt];
               tl_ff  <= bkt_tail[file_bkt];
            end
            CMD_FILE_WR: begin
               node_link[cur_i] <= Nil;
               if (hd_ff >= Nil) bkt_head[bkt_ff] <= cur_ff;
               else if (tl_ff < Nil) node_link[tl_ff[NW-1:0]] <= cur_ff;
               bkt_tail[bkt_ff] <= cur_ff;
               cur_ff <= nxt_ff;
            end
            CMD_ADVANCE: now_ff <= now_inc;
            CMD_CAS_HEAD: begin
               now_ff <= now_inc;
               nxt_ff <= bkt_head[cas_bkt];
               cur_ff <= Nil;
               bkt_head[cas_bkt] <= Nil;
               bkt_tail[cas_bkt] <= Nil;
            end
            // cascade: node list walk, pull next pointer before filing
            CMD_CAS_NEXT: begin
               cur_ff <= nxt_ff;
               nxt_ff <= node_link[nxt_ff[NW-1:0]];
               exp_ff <= node_expire[nxt_ff[NW-1:0]];
            end
            CMD_EXP_HEAD: cur_ff <= bkt_head[near_bkt];
            CMD_EXP_POP: begin
               ident_ff <= node_ident[cur_i];
               nxt_ff   <= node_link[cur_i];
               bkt_head[near_bkt] <= node_link[cur_i];
               if (node_link[cur_i] >= Nil) bkt_tail[near_bkt] <= Nil;
               node_link[cur_i] <= free_ff;
               free_ff  <= cur_ff;
               cur_ff   <= node_link[cur_i];
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      stat.clear_done = clr_done_ff;
      stat.pool_empty = free_ff >= Nil;
      stat.cas_needed = cas_need;
      stat.cur_valid  = nxt_ff < Nil;
      stat.exp_more   = cur_ff < Nil;
   end
   assign id_out = ident_ff;
endmodule
`default_nettype wire

FILE: dv/htw_checker.sv
`default_nettype none
module htw_checker
   import htw_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   htw_req_if        req,
   htw_rsp_if        rsp,
   output int        pending,
   output int        fails
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NearSlots  = 1 << NearBitsDef;
   localparam int LevelSlots = 1 << LevelBitsDef;
   localparam int Buckets    = NearSlots + Levels * LevelSlots;
   localparam int Pool       = PoolDepthDef;
   localparam int Nil        = Pool;

   typedef struct {
      logic [63:0] id;
      logic        status;
      logic        last;
   } expiry_type;

   expiry_type  due_q[$];
   logic [31:0] now_t;
   logic [31:0] when_n[Pool];
   logic [63:0] ident_n[Pool];
   int          link_n[Pool];
   int          head_b[Buckets];
   int          tail_b[Buckets];
   int          free_n;

   task automatic clear_wheel();
      now_t = '0;
      for (int i = 0; i < Pool; i++) link_n[i] = i + 1;
      for (int i = 0; i < Buckets; i++) begin
         head_b[i] = Nil;
         tail_b[i] = Nil;
      end
      free_n = 0;
   endtask

   task automatic append(int b, int n);
      link_n[n] = Nil;
      if (head_b[b] == Nil) head_b[b] = n;
      else link_n[tail_b[b]] = n;
      tail_b[b] = n;
   endtask

   task automatic place(int n);
      logic [63:0] t, cur, m;
      int lv;
      t   = {32'd0, when_n[n]};
      cur = {32'd0, now_t};
      m   = 64'(NearSlots - 1);
      if ((t | m) == (cur | m)) begin
         append(int'(t & m), n);
      end else begin
         m  = 64'(NearSlots) << LevelBitsDef;
         lv = 0;
         while (lv < 3 && (t | (m - 64'd1)) != (cur | (m - 64'd1))) begin
            m = m << LevelBitsDef;
            lv++;
         end
         append(NearSlots + lv * LevelSlots
                + int'((t >> (NearBitsDef + lv * LevelBitsDef)) & 64'(LevelSlots - 1)), n);
      end
   endtask

   task automatic refile(int lv, int slot);
      int b, c, nx, guard;
      b = NearSlots + lv * LevelSlots + slot;
      c = head_b[b];
      head_b[b] = Nil;
      tail_b[b] = Nil;
      guard = 0;
      while (c != Nil && guard < Pool) begin
         nx = link_n[c];
         place(c);
         c = nx;
         guard++;
      end
   endtask

   task automatic step_clock();
      logic [31:0] tm;
      logic [63:0] m;
      int lv;
      now_t = now_t + 32'd1;
      if (now_t == 32'd0) begin
         refile(3, 0);
      end else begin
         m  = 64'(NearSlots);
         tm = now_t >> NearBitsDef;
         lv = 0;
         while (lv < Levels && ({32'd0, now_t} & (m - 64'd1)) == 64'd0) begin
            if ((tm & 32'(LevelSlots - 1)) != 32'd0) begin
               refile(lv, int'(tm & 32'(LevelSlots - 1)));
               break;
            end
            m  = m << LevelBitsDef;
            tm = tm >> LevelBitsDef;
            lv++;
         end
      end
   endtask

   task automatic drain_slot();
      int b, n, cnt;
      expiry_type e;
      b   = int'(now_t & 32'(NearSlots - 1));
      cnt = 0;
      while (head_b[b] != Nil && cnt < MaxResults) begin
         n = head_b[b];
         head_b[b] = link_n[n];
         if (head_b[b] == Nil) tail_b[b] = Nil;
         e.id = ident_n[n];
         e.status = 1'b0;
         e.last = 1'b0;
         due_q.push_back(e);
         link_n[n] = free_n;
         free_n = n;
         cnt++;
      end
      if (cnt > 0) due_q[$].last = 1'b1;
   endtask

   task automatic apply_op(logic [1:0] op, logic [63:0] id, logic signed [31:0] dly);
      int n;
      expiry_type e;
      case (op)
         OP_INSERT: begin
            n = free_n;
            if (n == Nil) begin
               e.id = id;
               e.status = 1'b1;
               e.last = 1'b1;
               due_q.push_back(e);
            end else begin
               free_n = link_n[n];
               ident_n[n] = id;
               when_n[n] = now_t + ((dly < 0) ? 32'd0 : 32'(dly));
               place(n);
            end
         end
         OP_FLUSH: drain_slot();
         OP_TICK: begin
            step_clock();
            drain_slot();
         end
         default: ;
      endcase
   endtask

   initial begin
      fails = 0;
      pending = 0;
      clear_wheel();
   end

   always @(posedge clock) begin
      expiry_type e;
      if (reset) begin
         clear_wheel();
         due_q.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (due_q.size() == 0) begin
               $display("%0t: unexpected result id=%h status=%b last=%b", $time,
                        rsp.expired_id, rsp.status, rsp.last);
               fails++;
            end else begin
               e = due_q.pop_front();
               if (rsp.expired_id !== e.id || rsp.status !== e.status
                   || rsp.last !== e.last) begin
                  $display("%0t: mismatch expected id=%h status=%b last=%b, got id=%h status=%b last=%b",
                           $time, e.id, e.status, e.last, rsp.expired_id, rsp.status,
                           rsp.last);
                  fails++;
               end
            end
         end
         if (req.valid && req.ready) apply_op(req.operation, req.handle, req.delay);
      end
      pending = due_q.size();
   end
endmodule
`default_nettype wire

FILE: dv/tb.sv
`default_nettype none
module tb
   import htw_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 3000000;

   logic clock;
   logic reset;
   int   pending;
   int   fails;
   int   cycles;
   bit   hold_rsp;
   bit   timed_out;

   htw_req_if req ();
   htw_rsp_if rsp ();

   hierarchical_timer_wheel_top dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp)
   );

   htw_checker chk (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .pending(pending), .fails(fails)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit && !timed_out) begin
         timed_out = 1'b1;
         $display("FAIL");
         $finish;
      end
   end

   // result side: random stalls, calm stretches, and one long hold-off
   initial begin
      int mode, len;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_rsp = 1'b0;
         end
         mode = $urandom_range(0, 3);
         len  = $urandom_range(1, 40);
         repeat (len) begin
            if (mode == 0) rsp.ready <= 1'b1;
            else if (mode == 1) rsp.ready <= ($urandom_range(0, 3) != 0);
            else rsp.ready <= ($urandom_range(0, 1) != 0);
            @(negedge clock);
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic offer(logic [1:0] op, logic [63:0] id, logic signed [31:0] dly);
      req.valid     <= 1'b1;
      req.operation <= op;
      req.handle    <= id;
      req.delay     <= dly;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   task automatic pause(int n);
      req.valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic random_item();
      int pick;
      logic [63:0] id;
      logic signed [31:0] dly;
      id = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: dly = $urandom_range(0, 40);
         5, 6: dly = $urandom_range(0, 700);
         7: dly = $urandom_range(0, 40000);
         default: dly = $urandom;
      endcase
      if (pick < 45) offer(OP_INSERT, id, dly);
      else if (pick < 55) offer(OP_FLUSH, id, dly);
      else if (pick < 97) offer(OP_TICK, id, dly);
      else offer(OP_UNUSED, id, dly);
   endtask

   initial begin
      cycles = 0;
      timed_out = 1'b0;
      hold_rsp = 1'b0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.operation = OP_FLUSH;
      req.handle = '0;
      req.delay = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero and negative delays, flush, extreme ids and delays, an unused op and ticks
      offer(OP_INSERT, 64'h0, 32'sd0);
      offer(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, -32'sd1);
      offer(OP_INSERT, 64'h8000_0000_0000_0001, 32'sh8000_0000);
      offer(OP_FLUSH, '0, '0);
      offer(OP_FLUSH, '0, '0);
      offer(OP_INSERT, 64'hA5A5_5A5A_0F0F_F0F0, 32'sd1);
      offer(OP_INSERT, 64'h1, 32'sd2);
      offer(OP_INSERT, 64'h2, 32'sd256);
      offer(OP_INSERT, 64'h3, 32'sd16384);
      offer(OP_INSERT, 64'h4, 32'sd1048576);
      offer(OP_INSERT, 64'h5, 32'sh7FFF_FFFF);
      offer(OP_INSERT, 64'h6, 32'sd255);
      offer(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'sh7FFF_FFFF);
      offer(OP_TICK, '0, '0);
      offer(OP_TICK, '0, '0);
      offer(OP_TICK, '0, '0);
      for (int i = 0; i < 6; i++) offer(OP_INSERT, 64'(100 + i), 32'sd0);
      offer(OP_FLUSH, '0, '0);

      // back-to-back ticks
      for (int i = 0; i < 10; i++) offer(OP_TICK, '0, '0);

      for (int i = 0; i < 32; i++) begin
         if (i == 20) begin
            req.valid <= 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
         random_item();
         if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 12));
      end
      // fill the pool and overflow it while the receiver holds off
      hold_rsp = 1'b1;
      for (int i = 0; i < 62; i++) offer(OP_INSERT, {$urandom, $urandom}, $urandom_range(0, 3));
      offer(OP_FLUSH, '0, '0);
      for (int i = 0; i < 4; i++) offer(OP_TICK, '0, '0);
      pause(1);

      wait (pending == 0);
      repeat (300) @(posedge clock);
      if (fails == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire
